// ----- sv/heightfield_triangle_sampler_assert.svh -----
// Assertion macros used by the checker.
`ifndef HEIGHTFIELD_TRIANGLE_SAMPLER_ASSERT_SVH
`define HEIGHTFIELD_TRIANGLE_SAMPLER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define HTS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define HTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/hts_pkg.sv -----
`timescale 1ns / 1ps
package hts_pkg;
    localparam int unsigned MAX_COLS_DEF    = 256;
    localparam int unsigned MAX_ROWS_DEF    = 256;
    localparam int unsigned HEIGHT_BITS_DEF = 16;
    localparam int unsigned FRAC_BITS_DEF   = 16;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned COUNT_W    = 9;
    localparam int unsigned EXTENT_W   = 23;
    localparam int unsigned SCALE_W    = 24;
    localparam int unsigned WORLD_W    = 24;
    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned CELL_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE_Z  = 3'd5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Per-axis mapping settings handed to the axis units.
    typedef struct packed {
        logic [EXTENT_W-1:0] half;
        logic [SCALE_W-1:0]  scale;
    } axis_cfg_t;
endpackage

// ----- sv/heightfield_triangle_sampler.sv -----
`timescale 1ns / 1ps
// Heightfield triangle sampler. Load beats (op 0) write one height into the grid store;
// query beats (op 1) return one interpolated height with the cell and triangle used.
// One beat is taken every cycle while the output register is empty; a query's result
// passes through three axis stages, multiply for the row base, address add, store read
// and three blend stages. A result refused at the output moves into a one-beat output
// register while the pipe keeps moving; while that register is full the whole pipe and
// s_axis_tready stall. Loads travel down the pipe and write the store at the read stage,
// so a query sees every load accepted before it and none accepted after it. The user
// must write grid registers only while no beat is in flight; this is not enforced.
module heightfield_triangle_sampler #(
    parameter int unsigned MAX_COLS    = hts_pkg::MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS    = hts_pkg::MAX_ROWS_DEF,
    parameter int unsigned HEIGHT_BITS = hts_pkg::HEIGHT_BITS_DEF,
    parameter int unsigned FRAC_BITS   = hts_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [hts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: load_index[15:0], load_height[31:16], world_x[55:32], world_z[79:56]
    input  logic [79:0]                      s_axis_tdata,
    // tuser: op
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: height_out[15:0], cell_col[23:16], cell_row[31:24]
    output logic [31:0]                      m_axis_tdata,
    // tuser: upper_half
    output logic                             m_axis_tuser
);
    import hts_pkg::*;

    localparam int unsigned CX_W   = $clog2(MAX_COLS);
    localparam int unsigned CZ_W   = $clog2(MAX_ROWS);
    localparam int unsigned ADDR_W = CX_W + CZ_W;
    localparam int unsigned DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int unsigned LAT    = 9;
    localparam int unsigned LD_LAT = 5;

    // Configuration registers.
    logic [COUNT_W-1:0] grid_cols_reg, grid_rows_reg;
    axis_cfg_t          cfg_x_reg, cfg_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg   <= COUNT_W'(256);
            grid_rows_reg   <= COUNT_W'(256);
            cfg_x_reg.half  <= EXTENT_W'(65536);
            cfg_z_reg.half  <= EXTENT_W'(65536);
            cfg_x_reg.scale <= SCALE_W'(32640);
            cfg_z_reg.scale <= SCALE_W'(32640);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GRID_COLS:     grid_cols_reg   <= cfg_data[COUNT_W-1:0];
                REG_GRID_ROWS:     grid_rows_reg   <= cfg_data[COUNT_W-1:0];
                REG_HALF_EXTENT_X: cfg_x_reg.half  <= cfg_data[EXTENT_W-1:0];
                REG_HALF_EXTENT_Z: cfg_z_reg.half  <= cfg_data[EXTENT_W-1:0];
                REG_CELL_SCALE_X:  cfg_x_reg.scale <= cfg_data[SCALE_W-1:0];
                REG_CELL_SCALE_Z:  cfg_z_reg.scale <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective counts clamped to [2, MAX].
    logic [CX_W:0] cols;
    logic [CZ_W:0] rows;
    always_comb begin
        if (grid_cols_reg < COUNT_W'(2))             cols = (CX_W+1)'(2);
        else if (32'(grid_cols_reg) > MAX_COLS)     cols = (CX_W+1)'(MAX_COLS);
        else                                         cols = (CX_W+1)'(grid_cols_reg);
        if (grid_rows_reg < COUNT_W'(2))             rows = (CZ_W+1)'(2);
        else if (32'(grid_rows_reg) > MAX_ROWS)     rows = (CZ_W+1)'(MAX_ROWS);
        else                                         rows = (CZ_W+1)'(grid_rows_reg);
    end

    // Pipeline control: whole pipe advances unless the skid slot is full.
    logic           skid_valid_reg;
    logic           adv;
    logic [LAT-1:0] vld_reg;
    logic           in_acc;

    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], in_acc && (s_axis_tuser == OP_QUERY)};
        end
    end

    // Loads ride the pipe down to the read stage and write all banks there.
    logic                   ld_in;
    logic [LD_LAT-1:0]      ld_vld_reg;
    logic [ADDR_W-1:0]      ld_addr_reg [LD_LAT];
    logic [HEIGHT_BITS-1:0] ld_data_reg [LD_LAT];
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    assign ld_in = in_acc && (s_axis_tuser == OP_LOAD) && (32'(s_axis_tdata[15:0]) < DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ld_vld_reg <= '0;
        end else if (adv) begin
            ld_vld_reg <= {ld_vld_reg[LD_LAT-2:0], ld_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ld_addr_reg[0] <= ADDR_W'(s_axis_tdata[15:0]);
            ld_data_reg[0] <= HEIGHT_BITS'(s_axis_tdata[31:16]);
            for (int k = 1; k < LD_LAT; k++) begin
                ld_addr_reg[k] <= ld_addr_reg[k-1];
                ld_data_reg[k] <= ld_data_reg[k-1];
            end
        end
    end

    assign wr_en   = ld_vld_reg[LD_LAT-1] && adv;
    assign wr_addr = ld_addr_reg[LD_LAT-1];

    // Axis mapping, three stages.
    logic [CX_W-1:0]    col3;
    logic [CZ_W-1:0]    row3;
    logic [FRAC_BITS:0] fx3, fz3;

    hts_axis_map #(.IDX_W(CX_W), .FRAC_BITS(FRAC_BITS)) u_map_x (
        .aclk(aclk), .adv(adv), .world(s_axis_tdata[55:32]), .cfg(cfg_x_reg),
        .count(cols), .cell_idx(col3), .frac(fx3)
    );
    hts_axis_map #(.IDX_W(CZ_W), .FRAC_BITS(FRAC_BITS)) u_map_z (
        .aclk(aclk), .adv(adv), .world(s_axis_tdata[79:56]), .cfg(cfg_z_reg),
        .count(rows), .cell_idx(row3), .frac(fz3)
    );

    // Stage 4: row base product; stage 5: corner addresses.
    logic [ADDR_W-1:0]  rbase4_reg;
    logic [CX_W-1:0]    col4_reg, col5_reg, col6_reg, col7_reg, col8_reg, col9_reg;
    logic [CZ_W-1:0]    row4_reg, row5_reg, row6_reg, row7_reg, row8_reg, row9_reg;
    logic [FRAC_BITS:0] fx4_reg, fz4_reg, fx5_reg, fz5_reg;
    logic [ADDR_W-1:0]  rd_addr [4];
    logic [ADDR_W-1:0]  addr5_reg [4];
    logic [HEIGHT_BITS-1:0] rd_data [4];
    logic [ADDR_W-1:0]  base;

    always_ff @(posedge aclk) begin
        if (adv) begin
            rbase4_reg <= ADDR_W'(ADDR_W'(row3) * ADDR_W'(cols));
            col4_reg   <= col3;
            row4_reg   <= row3;
            fx4_reg    <= fx3;
            fz4_reg    <= fz3;
        end
    end

    assign base = rbase4_reg + ADDR_W'(col4_reg);
    always_ff @(posedge aclk) begin
        if (adv) begin
            addr5_reg[0] <= base;
            addr5_reg[1] <= base + ADDR_W'(1);
            addr5_reg[2] <= base + ADDR_W'(cols);
            addr5_reg[3] <= base + ADDR_W'(cols) + ADDR_W'(1);
            col5_reg     <= col4_reg;
            row5_reg     <= row4_reg;
            fx5_reg      <= fx4_reg;
            fz5_reg      <= fz4_reg;
        end
    end

    assign rd_addr = addr5_reg;

    // Stage 6: store read.
    logic [FRAC_BITS:0] fx6_reg, fz6_reg;
    hts_store #(.ADDR_W(ADDR_W), .HEIGHT_BITS(HEIGHT_BITS)) u_store (
        .aclk(aclk), .adv(adv), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_data(ld_data_reg[LD_LAT-1]), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            col6_reg <= col5_reg; row6_reg <= row5_reg;
            fx6_reg  <= fx5_reg;  fz6_reg  <= fz5_reg;
            col7_reg <= col6_reg; row7_reg <= row6_reg;
            col8_reg <= col7_reg; row8_reg <= row7_reg;
            col9_reg <= col8_reg; row9_reg <= row8_reg;
        end
    end

    // Stages 7 to 9: blend.
    logic [HEIGHT_BITS-1:0] height9;
    logic                   upper9;
    hts_blend #(.HEIGHT_BITS(HEIGHT_BITS), .FRAC_BITS(FRAC_BITS)) u_blend (
        .aclk(aclk), .adv(adv), .fx(fx6_reg), .fz(fz6_reg),
        .h00(rd_data[0]), .h10(rd_data[1]), .h01(rd_data[2]), .h11(rd_data[3]),
        .height(height9), .upper(upper9)
    );

    // Pipe output beat and skid slot.
    logic [31:0] pipe_data;
    logic [31:0] skid_data_reg;
    logic        skid_user_reg;
    logic        pipe_valid;

    assign pipe_valid = vld_reg[LAT-1] && adv;
    assign pipe_data  = {CELL_W'(row9_reg), CELL_W'(col9_reg), FIELD_W'(height9)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_axis_tready) skid_valid_reg <= 1'b0;
        end else if (pipe_valid && !m_axis_tready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            skid_data_reg <= pipe_data;
            skid_user_reg <= upper9;
        end
    end

    assign m_axis_tvalid = skid_valid_reg || pipe_valid;
    assign m_axis_tdata  = skid_valid_reg ? skid_data_reg : pipe_data;
    assign m_axis_tuser  = skid_valid_reg ? skid_user_reg : upper9;
endmodule

// ----- sv/hts_axis_map.sv -----
`timescale 1ns / 1ps
// One axis: clamp, offset, scale, split into cell and fraction, far edge saturation.
// Three register stages: offset, product, cell/fraction.
module hts_axis_map #(
    parameter int unsigned IDX_W     = 8,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          adv,
    input  logic [hts_pkg::WORLD_W-1:0]   world,
    input  hts_pkg::axis_cfg_t            cfg,
    input  logic [IDX_W:0]                count,
    output logic [IDX_W-1:0]              cell_idx,
    output logic [FRAC_BITS:0]            frac
);
    import hts_pkg::*;

    localparam int unsigned T_W = EXTENT_W + 1;
    localparam int unsigned G_W = T_W + SCALE_W;

    logic signed [WORLD_W:0] w_s;
    logic signed [WORLD_W:0] h_s;
    logic signed [WORLD_W:0] wc;
    logic [T_W-1:0]          t_reg;
    logic [SCALE_W-1:0]      scale_reg;
    logic [G_W-1:0]          g_reg;
    logic [G_W-25:0]         c_full;
    logic [IDX_W-1:0]        cell_reg;
    logic [FRAC_BITS:0]      frac_reg;

    // Stage 1: clamp to [-half, half] and offset by half.
    assign w_s = {world[WORLD_W-1], world};
    assign h_s = {2'b00, cfg.half};
    always_comb begin
        wc = w_s;
        if (w_s < -h_s) begin
            wc = -h_s;
        end else if (w_s > h_s) begin
            wc = h_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg     <= T_W'(wc + h_s);
            scale_reg <= cfg.scale;
        end
    end

    // Stage 2: scale into grid units with 24 fraction bits.
    always_ff @(posedge aclk) begin
        if (adv) begin
            g_reg <= G_W'(t_reg) * G_W'(scale_reg);
        end
    end

    // Stage 3: cell index with saturation at the last cell.
    assign c_full = g_reg[G_W-1:24];
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (c_full >= (G_W-24)'(count - 1'b1)) begin
                cell_reg <= IDX_W'(count - 2'd2);
                frac_reg <= {1'b1, {FRAC_BITS{1'b0}}};
            end else begin
                cell_reg <= IDX_W'(c_full);
                frac_reg <= {1'b0, g_reg[23 -: FRAC_BITS]};
            end
        end
    end

    assign cell_idx = cell_reg;
    assign frac     = frac_reg;
endmodule

// ----- sv/hts_blend.sv -----
`timescale 1ns / 1ps
// Triangle select and barycentric blend: weights, products, sum and rounding.
module hts_blend #(
    parameter int unsigned HEIGHT_BITS = 16,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic                   aclk,
    input  logic                   adv,
    input  logic [FRAC_BITS:0]     fx,
    input  logic [FRAC_BITS:0]     fz,
    input  logic [HEIGHT_BITS-1:0] h00,
    input  logic [HEIGHT_BITS-1:0] h10,
    input  logic [HEIGHT_BITS-1:0] h01,
    input  logic [HEIGHT_BITS-1:0] h11,
    output logic [HEIGHT_BITS-1:0] height,
    output logic                   upper
);
    import hts_pkg::*;

    localparam int unsigned W_W = FRAC_BITS + 1;
    localparam int unsigned P_W = HEIGHT_BITS + W_W;
    localparam int unsigned S_W = P_W + 2;
    localparam logic [FRAC_BITS+1:0] ONE = {2'b01, {FRAC_BITS{1'b0}}};

    logic [FRAC_BITS+1:0] fsum;
    logic                 up_c;
    logic [W_W-1:0]       wa_reg, wb_reg, wc_reg;
    logic [HEIGHT_BITS-1:0] ha_reg, hb_reg, hc_reg;
    logic                 up1_reg, up2_reg, up3_reg;
    logic [P_W-1:0]       pa_reg, pb_reg, pc_reg;
    logic [S_W-1:0]       sum;
    logic [HEIGHT_BITS-1:0] height_reg;

    // Stage A: triangle choice and weights.
    assign fsum = {1'b0, fx} + {1'b0, fz};
    assign up_c = (fsum <= ONE);
    always_ff @(posedge aclk) begin
        if (adv) begin
            up1_reg <= up_c;
            if (up_c) begin
                wa_reg <= W_W'(ONE - fsum);
                wb_reg <= fx;
                wc_reg <= fz;
                ha_reg <= h00;
                hb_reg <= h10;
                hc_reg <= h01;
            end else begin
                wa_reg <= W_W'(ONE - {1'b0, fz});
                wb_reg <= W_W'(ONE - {1'b0, fx});
                wc_reg <= W_W'(fsum - ONE);
                ha_reg <= h10;
                hb_reg <= h01;
                hc_reg <= h11;
            end
        end
    end

    // Stage B: three products.
    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_reg  <= P_W'(ha_reg) * P_W'(wa_reg);
            pb_reg  <= P_W'(hb_reg) * P_W'(wb_reg);
            pc_reg  <= P_W'(hc_reg) * P_W'(wc_reg);
            up2_reg <= up1_reg;
        end
    end

    // Stage C: sum, round half up.
    assign sum = S_W'(pa_reg) + S_W'(pb_reg) + S_W'(pc_reg) + S_W'(ONE >> 1);
    always_ff @(posedge aclk) begin
        if (adv) begin
            height_reg <= sum[FRAC_BITS +: HEIGHT_BITS];
            up3_reg    <= up2_reg;
        end
    end

    assign height = height_reg;
    assign upper  = up3_reg;
endmodule

// ----- sv/hts_store.sv -----
`timescale 1ns / 1ps
// Height store: four copies, one per corner, each written alike and read once a cycle while adv is high.
module hts_store #(
    parameter int unsigned ADDR_W      = 16,
    parameter int unsigned HEIGHT_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   adv,
    input  logic                   wr_en,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  logic [HEIGHT_BITS-1:0] wr_data,
    input  logic [ADDR_W-1:0]      rd_addr [4],
    output logic [HEIGHT_BITS-1:0] rd_data [4]
);
    import hts_pkg::*;

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [HEIGHT_BITS-1:0] mem [2**ADDR_W];
        logic [HEIGHT_BITS-1:0] q_reg;
        always_ff @(posedge aclk) begin
            if (wr_en) begin
                mem[wr_addr] <= wr_data;
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                q_reg <= mem[rd_addr[k]];
            end
        end
        assign rd_data[k] = q_reg;
    end
endmodule

// ----- sv/hts_checker.sv -----
`timescale 1ns / 1ps
`include "heightfield_triangle_sampler_assert.svh"
// Port-level checks on the sampler.
module hts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import hts_pkg::*;

    // A stalled result holds its payload.
    `HTS_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && m_axis_tvalid, "result changed under stall")
    // A stalled result holds its triangle flag.
    `HTS_ASSERT_NEXT(a_user, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tuser), "upper flag changed under stall")
    // Input is refused only while a result waits.
    `HTS_ASSERT_IMP(a_ready, aclk, aresetn, !s_axis_tready, m_axis_tvalid, "input stalled with no result pending")
endmodule

bind heightfield_triangle_sampler hts_checker u_hts_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
